// ----- rtl/mbsd_pkg.sv -----
// Package for the MIDI byte stream decoder: parse state codes, message kind
// codes, the result record and the message classification functions.
// Depends on nothing.
package mbsd_pkg;

  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_ONE    = 3'd2;
  localparam logic [2:0] ST_FIRST  = 3'd3;
  localparam logic [2:0] ST_SECOND = 3'd4;
  localparam logic [2:0] ST_SYSEX  = 3'd5;

  localparam logic [3:0] KIND_SINGLE     = 4'd0;
  localparam logic [3:0] KIND_NOTE_OFF   = 4'd1;
  localparam logic [3:0] KIND_NOTE_ON    = 4'd2;
  localparam logic [3:0] KIND_POLY_PRESS = 4'd3;
  localparam logic [3:0] KIND_CONTROL    = 4'd4;
  localparam logic [3:0] KIND_PROGRAM    = 4'd5;
  localparam logic [3:0] KIND_CHAN_PRESS = 4'd6;
  localparam logic [3:0] KIND_BEND       = 4'd7;
  localparam logic [3:0] KIND_OTHER_TWO  = 4'd8;
  localparam logic [3:0] KIND_OTHER_THREE = 4'd9;

  localparam logic [7:0] SYSEX_END     = 8'hf7;
  localparam logic [7:0] REALTIME_MASK = 8'hf8;
  localparam logic [6:0] DATA_MAX      = 7'h7f;

  typedef struct packed {
    logic [3:0]  kind;
    logic        typed;
    logic [1:0]  len;
    logic [7:0]  status;
    logic [3:0]  channel;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [13:0] bend;
  } msg_t;

  function automatic msg_t make_msg(logic [3:0] kind, logic typed, logic [1:0] len,
                                    logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                    logic [13:0] bend);
    msg_t m;
    m.kind        = kind;
    m.typed       = typed;
    m.len         = len;
    m.status      = st;
    m.channel     = st[3:0];
    m.data_first  = d1;
    m.data_second = d2;
    m.bend        = bend;
    return m;
  endfunction

  function automatic logic [2:0] classify(logic [7:0] st);
    logic [2:0] hi;
    logic [3:0] lo;
    logic [2:0] r;
    hi = st[6:4];
    lo = st[3:0];
    if (hi < 3'd4 || hi == 3'd6) r = ST_FIRST;
    else if (hi < 3'd6) r = ST_ONE;
    else if (lo == 4'h0) r = ST_SYSEX;
    else if (lo == 4'h2) r = ST_FIRST;
    else if (lo == 4'h3) r = ST_ONE;
    else r = ST_START;
    return r;
  endfunction

  function automatic msg_t two_byte(logic [7:0] st, logic [6:0] d1);
    msg_t m;
    case (st[6:4])
      3'd4:    m = make_msg(KIND_PROGRAM, 1'b1, 2'd2, st, d1, 7'd0, 14'd0);
      3'd5:    m = make_msg(KIND_CHAN_PRESS, 1'b1, 2'd2, st, d1, 7'd0, 14'd0);
      default: m = make_msg(KIND_OTHER_TWO, 1'b0, 2'd2, st, d1, 7'd0, 14'd0);
    endcase
    return m;
  endfunction

  function automatic msg_t three_byte(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    msg_t m;
    case (st[6:4])
      3'd0: m = make_msg(KIND_NOTE_OFF, 1'b1, 2'd3, st, d1, d2, 14'd0);
      3'd1: begin
        if (d2 != 7'd0) m = make_msg(KIND_NOTE_ON, 1'b1, 2'd3, st, d1, d2, 14'd0);
        else m = make_msg(KIND_NOTE_OFF, 1'b0, 2'd3, st, d1, DATA_MAX, 14'd0);
      end
      3'd2:    m = make_msg(KIND_POLY_PRESS, 1'b1, 2'd3, st, d1, d2, 14'd0);
      3'd3:    m = make_msg(KIND_CONTROL, 1'b1, 2'd3, st, d1, d2, 14'd0);
      3'd6:    m = make_msg(KIND_BEND, 1'b1, 2'd3, st, d1, d2, {d2, d1});
      default: m = make_msg(KIND_OTHER_THREE, 1'b0, 2'd3, st, d1, d2, 14'd0);
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/mbsd_step.sv -----
// Next-state and message logic for one received MIDI byte.
// Depends on mbsd_pkg.
module mbsd_step (
  input  logic [2:0]    state_i,
  input  logic [7:0]    held_status_i,
  input  logic [6:0]    held_data_i,
  input  logic [7:0]    in_byte_i,
  output logic [2:0]    state_o,
  output logic [7:0]    held_status_o,
  output logic [6:0]    held_data_o,
  output logic          msg_valid_o,
  output mbsd_pkg::msg_t msg_o
);

  logic       cmd;
  logic       done;
  logic [2:0] s;

  assign cmd = in_byte_i[7];

  always_comb begin
    s             = state_i;
    done          = 1'b0;
    held_status_o = held_status_i;
    held_data_o   = held_data_i;
    msg_valid_o   = 1'b0;
    msg_o = mbsd_pkg::make_msg(mbsd_pkg::KIND_SINGLE, 1'b0, 2'd1, in_byte_i,
                               7'd0, 7'd0, 14'd0);

    if (s > mbsd_pkg::ST_SYSEX) s = mbsd_pkg::ST_START;
    if (s == mbsd_pkg::ST_RUN) s = cmd ? mbsd_pkg::ST_START : mbsd_pkg::classify(held_status_i);
    if (cmd && (s inside {mbsd_pkg::ST_ONE, mbsd_pkg::ST_FIRST, mbsd_pkg::ST_SECOND}))
      s = mbsd_pkg::ST_START;

    if (s == mbsd_pkg::ST_SYSEX) begin
      if ((in_byte_i & mbsd_pkg::REALTIME_MASK) == mbsd_pkg::REALTIME_MASK) begin
        msg_valid_o = 1'b1;
        done        = 1'b1;
      end else if (in_byte_i == mbsd_pkg::SYSEX_END) begin
        s    = mbsd_pkg::ST_START;
        done = 1'b1;
      end else if (cmd) begin
        s = mbsd_pkg::ST_START;
      end else begin
        done = 1'b1;
      end
    end

    if (!done) begin
      case (s)
        mbsd_pkg::ST_ONE: begin
          s           = mbsd_pkg::ST_RUN;
          msg_valid_o = 1'b1;
          msg_o       = mbsd_pkg::two_byte(held_status_i, in_byte_i[6:0]);
        end
        mbsd_pkg::ST_FIRST: begin
          held_data_o = in_byte_i[6:0];
          s           = mbsd_pkg::ST_SECOND;
        end
        mbsd_pkg::ST_SECOND: begin
          s           = mbsd_pkg::ST_RUN;
          msg_valid_o = 1'b1;
          msg_o       = mbsd_pkg::three_byte(held_status_i, held_data_i, in_byte_i[6:0]);
        end
        default: begin
          if (cmd) begin
            held_status_o = in_byte_i;
            s             = mbsd_pkg::classify(in_byte_i);
            if (s == mbsd_pkg::ST_START) msg_valid_o = 1'b1;
          end
        end
      endcase
    end

    state_o = s;
  end

endmodule

// ----- rtl/midi_byte_stream_decoder_core.sv -----
// MIDI byte stream decoder top level: parse state registers and result register.
// Depends on mbsd_pkg and mbsd_step.
// A completed message is registered and shows on the output in the cycle after its last byte.
// Throughput: one byte per cycle; a byte is taken whenever the result register
// is empty or its message is taken in the same cycle.
// Reset: parse state returns to waiting for status, held status and data clear.
module midi_byte_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  msg_kind_o,
  output logic        typed_o,
  output logic [1:0]  msg_len_o,
  output logic [7:0]  status_byte_o,
  output logic [3:0]  channel_o,
  output logic [6:0]  data_first_o,
  output logic [6:0]  data_second_o,
  output logic [13:0] bend_value_o
);

  logic [2:0]     state_q, state_d;
  logic [7:0]     held_status_q, held_status_d;
  logic [6:0]     held_data_q, held_data_d;
  logic           out_valid_q;
  mbsd_pkg::msg_t out_msg_q;
  mbsd_pkg::msg_t msg_d;
  logic           msg_valid;
  logic           accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  mbsd_step u_step (
    .state_i       (state_q),
    .held_status_i (held_status_q),
    .held_data_i   (held_data_q),
    .in_byte_i     (in_byte_i),
    .state_o       (state_d),
    .held_status_o (held_status_d),
    .held_data_o   (held_data_d),
    .msg_valid_o   (msg_valid),
    .msg_o         (msg_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mbsd_pkg::ST_START;
      held_status_q <= 8'd0;
      held_data_q   <= 7'd0;
      out_valid_q   <= 1'b0;
    end else if (accept) begin
      state_q       <= state_d;
      held_status_q <= held_status_d;
      held_data_q   <= held_data_d;
      out_valid_q   <= msg_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && msg_valid) begin
      out_msg_q <= msg_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign msg_kind_o    = out_msg_q.kind;
  assign typed_o       = out_msg_q.typed;
  assign msg_len_o     = out_msg_q.len;
  assign status_byte_o = out_msg_q.status;
  assign channel_o     = out_msg_q.channel;
  assign data_first_o  = out_msg_q.data_first;
  assign data_second_o = out_msg_q.data_second;
  assign bend_value_o  = out_msg_q.bend;

`ifndef SYNTHESIS
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= mbsd_pkg::ST_SYSEX)
    else $error("parse state out of range");

  a_status_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_byte_o[7] && msg_len_o != 2'd0)
    else $error("result without a status byte");

  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_kind_o == mbsd_pkg::KIND_SINGLE |-> msg_len_o == 2'd1)
    else $error("single byte message with wrong length");

  a_idle_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_byte_i[7] && state_q == mbsd_pkg::ST_START |=> !out_valid_o)
    else $error("stray data byte produced a message");
`endif

endmodule
